/* hw/rtl/double_ended_queue_unit_defines.svh */
// Assertion macros for the double-ended queue unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("deque assertion failed");
`define DEQ_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("deque assertion failed");
`else
`define DEQ_ASSERT(lbl, clk, rstn, prop)
`define DEQ_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

/* hw/rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Used by deq_ctrl, deq_dpath and double_ended_queue_unit; no dependencies.
`default_nettype none

package deq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountOutW    = 5;
  localparam int unsigned OpW          = 2;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [OpW-1:0] {
    OpPushFront = 2'd0,
    OpPushBack  = 2'd1,
    OpPopFront  = 2'd2,
    OpPopBack   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StsOk    = 2'd0,
    StsEmpty = 2'd1,
    StsFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } deq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/deq_ctrl.sv */
// Controller state machine of the double-ended queue unit.
// Depends on deq_pkg and double_ended_queue_unit_defines.svh.
`default_nettype none

`include "double_ended_queue_unit_defines.svh"

module deq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  output logic                   done_o,
  output deq_pkg::deq_cmd_t      cmd_o
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == StExec);
  assign done_o = (state_q == StDone);
  assign accept = start_i & ~busy_o;

  assign cmd_o.capture = accept;
  assign cmd_o.execute = busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        state_d = StDone;
      end
      StDone: begin
        state_d = accept ? StExec : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `DEQ_ASSERT(a_exec_then_done, clk_i, rst_ni, busy_o |=> done_o)
  `DEQ_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(busy_o))
  `DEQ_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))

endmodule

`default_nettype wire

/* hw/rtl/deq_dpath.sv */
// Datapath of the double-ended queue unit: entry memory, front pointer and count.
// Depends on deq_pkg and double_ended_queue_unit_defines.svh.
`default_nettype none

`include "double_ended_queue_unit_defines.svh"

module deq_dpath #(
  parameter int unsigned DEPTH = deq_pkg::DepthDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire deq_pkg::deq_cmd_t                    cmd_i,
  input  wire logic [deq_pkg::OpW-1:0]              opcode_i,
  input  wire logic signed [deq_pkg::ValueW-1:0]    push_value_i,
  output logic signed [deq_pkg::ValueW-1:0]         popped_value_o,
  output logic [deq_pkg::CountOutW-1:0]             element_count_o,
  output logic [deq_pkg::StatusW-1:0]               status_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW:0]   DepthSum = (CntW + 1)'(DEPTH);

  logic [ValueW-1:0] mem [DEPTH];

  op_e               op_q;
  logic [ValueW-1:0] val_q;
  logic [IdxW-1:0]   front_q, front_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ValueW-1:0] rd_q;
  logic              pop_ok_q;
  status_e           status_q, status_d;

  logic            is_push, at_front, full, empty, wr_en, rd_en;
  logic [CntW-1:0] offset;
  logic [CntW:0]   sum_raw, sum_wrap;
  logic [IdxW-1:0] back_idx, front_dec, front_inc, addr;
  logic [CntW+CountOutW-1:0] cnt_ext;

  assign is_push  = (op_q == OpPushFront) || (op_q == OpPushBack);
  assign at_front = (op_q == OpPushFront) || (op_q == OpPopFront);
  assign full     = (count_q == DepthCnt);
  assign empty    = (count_q == '0);

  assign offset    = is_push ? count_q : count_q - CntW'(1);
  assign sum_raw   = (CntW + 1)'(front_q) + (CntW + 1)'(offset);
  assign sum_wrap  = (sum_raw >= DepthSum) ? sum_raw - DepthSum : sum_raw;
  assign back_idx  = sum_wrap[IdxW-1:0];
  assign front_dec = (front_q == '0) ? LastIdx : front_q - IdxW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + IdxW'(1);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = StsOk;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    addr     = back_idx;
    if (is_push) begin
      if (full) begin
        status_d = StsFull;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
        if (at_front) begin
          addr    = front_dec;
          front_d = front_dec;
        end
      end
    end else begin
      if (empty) begin
        status_d = StsEmpty;
      end else begin
        rd_en   = 1'b1;
        count_d = count_q - CntW'(1);
        if (at_front) begin
          addr    = front_q;
          front_d = front_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && wr_en) begin
      mem[addr] <= val_q;
    end
    if (cmd_i.execute && rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      val_q <= push_value_i;
    end
    if (cmd_i.execute) begin
      pop_ok_q <= rd_en;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.execute) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  assign cnt_ext         = {{CountOutW{1'b0}}, count_q};
  assign element_count_o = cnt_ext[CountOutW-1:0];
  assign popped_value_o  = pop_ok_q ? rd_q : '0;
  assign status_o        = status_q;

  `DEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DepthCnt)
  `DEQ_ASSERT(a_front_bound, clk_i, rst_ni, front_q <= LastIdx)
  `DEQ_ASSERT(a_full_push_holds, clk_i, rst_ni,
              (cmd_i.execute && is_push && full) |=> $stable(count_q) && $stable(front_q))
  `DEQ_ASSERT(a_idle_holds, clk_i, rst_ni,
              !cmd_i.execute |=> $stable(count_q) && $stable(front_q))

endmodule

`default_nettype wire

/* hw/rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// A word (opcode and push value) is taken at a rising edge with start_i high and busy_o low.
// The opcode and value are registered, then the Exec state runs, and the result shows on
// popped_value_o, element_count_o and status_o, marked by done_o for exactly one cycle; the
// receiver cannot stall it, so capture it then. busy_o is high for the one cycle in which the
// entry memory is read or written and the front pointer and count are updated; a new word
// may be started in the cycle that presents the previous result, but not while busy_o is
// high. A pop from an empty queue returns 0 with status 1, and a push to a full queue is
// dropped with status 2.
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = deq_pkg::DepthDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [deq_pkg::OpW-1:0]              opcode_i,
  input  wire logic signed [deq_pkg::ValueW-1:0]    push_value_i,
  output logic                                      done_o,
  output logic signed [deq_pkg::ValueW-1:0]         popped_value_o,
  output logic [deq_pkg::CountOutW-1:0]             element_count_o,
  output logic [deq_pkg::StatusW-1:0]               status_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (opcode_i),
    .push_value_i    (push_value_i),
    .popped_value_o  (popped_value_o),
    .element_count_o (element_count_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for double_ended_queue_unit: directed and random push/pop words,
// a behavioral deque predicts every result and the monitor compares it field by field.
// Depends on deq_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import deq_pkg::*;

  localparam int unsigned Depth = DepthDefault;
  localparam int unsigned RandomWords = 1950;

  typedef struct {
    op_e                      op;
    logic signed [ValueW-1:0] value;
    int unsigned              gap;
    bit                       drain;
  } deque_word_t;

  typedef struct {
    logic signed [ValueW-1:0] popped;
    logic [CountOutW-1:0]     count;
    status_e                  status;
  } deque_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  op_e                      opcode_i = OpPushFront;
  logic signed [ValueW-1:0] push_value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic signed [ValueW-1:0] popped_value_o;
  logic [CountOutW-1:0]     element_count_o;
  logic [StatusW-1:0]       status_o;

  deque_word_t   words_to_send[$];
  deque_result_t results_due[$];

  logic [ValueW-1:0] shadow_store[Depth];
  int unsigned       shadow_front = 0;
  int unsigned       shadow_count = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       idle_left = 0;
  bit                word_fresh = 1'b1;
  int unsigned       burst_left = 0;

  double_ended_queue_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .element_count_o(element_count_o),
    .status_o       (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void apply_deque_op(input op_e op, input logic [ValueW-1:0] value);
    deque_result_t r;
    r.popped = '0;
    r.status = StsOk;
    if (op == OpPushFront || op == OpPushBack) begin
      if (shadow_count >= Depth) begin
        r.status = StsFull;
      end else if (op == OpPushFront) begin
        shadow_front = (shadow_front + Depth - 1) % Depth;
        shadow_store[shadow_front] = value;
        shadow_count++;
      end else begin
        shadow_store[(shadow_front + shadow_count) % Depth] = value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = StsEmpty;
      end else if (op == OpPopFront) begin
        r.popped = shadow_store[shadow_front];
        shadow_front = (shadow_front + 1) % Depth;
        shadow_count--;
      end else begin
        r.popped = shadow_store[(shadow_front + shadow_count - 1) % Depth];
        shadow_count--;
      end
    end
    r.count = shadow_count[CountOutW-1:0];
    results_due.push_back(r);
  endfunction

  function automatic int unsigned next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    return 0;
  endfunction

  function automatic void queue_word(input op_e op, input logic [ValueW-1:0] value);
    deque_word_t w;
    w.op = op;
    w.value = value;
    w.gap = next_gap();
    w.drain = 1'b0;
    words_to_send.push_back(w);
  endfunction

  function automatic void queue_drain();
    deque_word_t w;
    w.op = OpPushFront;
    w.value = '0;
    w.gap = 0;
    w.drain = 1'b1;
    words_to_send.push_back(w);
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit          accepted;
    bit          launch;
    deque_word_t w;
    if (!rst_ni) begin
      start_i <= 1'b0;
      opcode_i <= OpPushFront;
      push_value_i <= '0;
      idle_left = 0;
      word_fresh = 1'b1;
    end else begin
      accepted = start_i && !busy_o;
      launch = 1'b0;
      if (accepted) begin
        apply_deque_op(words_to_send[0].op, words_to_send[0].value);
        void'(words_to_send.pop_front());
        word_fresh = 1'b1;
      end
      if (!start_i || accepted) begin
        if (words_to_send.size() > 0) begin
          w = words_to_send[0];
          if (word_fresh) begin
            idle_left = w.gap;
            word_fresh = 1'b0;
          end
          if (idle_left > 0) begin
            idle_left--;
          end else if (w.drain) begin
            if (results_due.size() == 0 && !accepted) begin
              void'(words_to_send.pop_front());
              word_fresh = 1'b1;
            end
          end else begin
            launch = 1'b1;
            opcode_i <= w.op;
            push_value_i <= w.value;
          end
        end
        start_i <= launch;
      end
    end
  end

  always @(posedge clk_i) begin
    deque_result_t due;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result: popped %0d count %0d status %0d",
                   popped_value_o, element_count_o, status_o);
        end
      end else begin
        due = results_due.pop_front();
        if (popped_value_o !== due.popped || element_count_o !== due.count ||
            status_o !== due.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: popped %0d count %0d status %0d, expected %0d %0d %0d",
                     popped_value_o, element_count_o, status_o,
                     due.popped, due.count, due.status);
          end
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_bias;
    bit          front;
    queue_word(OpPopFront, 32'h1234_5678);
    queue_word(OpPopBack, '1);
    queue_word(OpPushFront, 32'h7fff_ffff);
    queue_word(OpPushBack, 32'h8000_0000);
    queue_word(OpPopBack, '0);
    queue_word(OpPopFront, '0);
    for (int i = 0; i < Depth; i++) begin
      queue_word((i % 2 == 0) ? OpPushFront : OpPushBack, 32'ha5a5_0000 ^ (i * 32'h0101_0101));
    end
    queue_word(OpPushFront, '1);
    queue_word(OpPushBack, '0);
    queue_drain();
    queue_word(OpPopFront, '0);
    queue_word(OpPopBack, '0);

    sent = 0;
    while (sent < RandomWords) begin
      phase_len = $urandom_range(4, 48);
      case ($urandom_range(0, 2))
        0: push_bias = 80;
        1: push_bias = 50;
        default: push_bias = 20;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        front = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < push_bias) begin
          queue_word(front ? OpPushFront : OpPushBack, random_value());
        end else begin
          queue_word(front ? OpPopFront : OpPopBack, random_value());
        end
        sent++;
        if (sent % 400 == 0) begin
          queue_drain();
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (words_to_send.size() != 0 || results_due.size() != 0);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dpath.sv
hw/rtl/double_ended_queue_unit.sv
sim/testbench.sv
